// ===== sv/sfdd_pkg.sv =====
package sfdd_pkg;

  // sync pair, shortest legal frame and reset minimum frame length
  localparam logic [7:0] SYNC_FIRST     = 8'hAA;
  localparam logic [7:0] SYNC_SECOND    = 8'h55;
  localparam logic [7:0] SHORTEST_FRAME = 8'd6;
  localparam logic [7:0] MIN_BYTES_RST  = 8'd11;

  // frame positions of the captured bytes
  localparam logic [7:0] POS_LENGTH    = 8'd2;
  localparam logic [7:0] POS_COMMAND   = 8'd3;
  localparam logic [7:0] POS_DATA_HIGH = 8'd4;
  localparam logic [7:0] POS_DATA_LOW  = 8'd5;

  // command codes
  localparam logic [7:0] CMD_LIGHT  = 8'd0;
  localparam logic [7:0] CMD_BUTTON = 8'd1;

  // result kinds
  localparam logic [1:0] KIND_LIGHT  = 2'd0;
  localparam logic [1:0] KIND_BUTTON = 2'd1;
  localparam logic [1:0] KIND_OTHER  = 2'd2;
  localparam logic [1:0] KIND_SHORT  = 2'd3;

  // one decoded frame
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  command;
    logic [10:0] light_integer;
    logic [3:0]  light_fraction;
    logic        motion;
    logic [7:0]  button_event;
    logic [7:0]  frame_length;
    logic [15:0] frame_seq;
  } result_t;

endpackage

// ===== sv/sfdd_deframer.sv =====
module sfdd_deframer (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    byte_valid,
  input  logic [7:0]              rx_byte,
  input  logic [7:0]              min_frame_bytes,
  output logic                    res_valid,
  output sfdd_pkg::result_t       res
);
  import sfdd_pkg::*;

  // hunt state codes
  localparam logic [1:0] HUNT_IDLE  = 2'd0;
  localparam logic [1:0] HUNT_SYNC  = 2'd1;
  localparam logic [1:0] HUNT_FRAME = 2'd2;

  logic [1:0]  hunt_r, hunt_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [7:0]  command_r, command_nxt;
  logic [7:0]  data_hi_r, data_hi_nxt;
  logic [7:0]  data_lo_r, data_lo_nxt;
  logic [15:0] frame_cnt_r, frame_cnt_nxt;
  logic [8:0]  count;
  logic [7:0]  min_eff;
  logic [7:0]  need;
  logic        done;
  logic [15:0] data_word;

  // bytes counted from sync needed before release
  assign count   = {1'b0, pos_r} + 9'd1;
  assign min_eff = (min_frame_bytes < SHORTEST_FRAME) ? SHORTEST_FRAME : min_frame_bytes;
  assign need    = (length_nxt > min_eff) ? length_nxt : min_eff;

  // sync hunt, byte capture and frame release
  always_comb begin
    hunt_nxt      = hunt_r;
    pos_nxt       = pos_r;
    length_nxt    = length_r;
    command_nxt   = command_r;
    data_hi_nxt   = data_hi_r;
    data_lo_nxt   = data_lo_r;
    frame_cnt_nxt = frame_cnt_r;
    done          = 1'b0;
    if (byte_valid) begin
      case (hunt_r)
        HUNT_SYNC: begin
          if (rx_byte == SYNC_SECOND) begin
            hunt_nxt = HUNT_FRAME;
            pos_nxt  = POS_LENGTH;
          end else if (rx_byte != SYNC_FIRST) begin
            hunt_nxt = HUNT_IDLE;
          end
        end
        HUNT_FRAME: begin
          if (pos_r == POS_LENGTH)    length_nxt  = rx_byte;
          if (pos_r == POS_COMMAND)   command_nxt = rx_byte;
          if (pos_r == POS_DATA_HIGH) data_hi_nxt = rx_byte;
          if (pos_r == POS_DATA_LOW)  data_lo_nxt = rx_byte;
          if (count < {1'b0, need}) begin
            pos_nxt = count[7:0];
          end else begin
            hunt_nxt      = HUNT_IDLE;
            pos_nxt       = 8'd0;
            frame_cnt_nxt = frame_cnt_r + 16'd1;
            done          = 1'b1;
          end
        end
        default: begin
          // unused code behaves as hunting
          hunt_nxt = (rx_byte == SYNC_FIRST) ? HUNT_SYNC : HUNT_IDLE;
          pos_nxt  = 8'd0;
        end
      endcase
    end
  end

  // decode of the frame being released
  assign data_word = {data_hi_nxt, data_lo_nxt};

  always_comb begin
    res                = '0;
    res.command        = command_nxt;
    res.frame_length   = length_nxt;
    res.frame_seq      = frame_cnt_nxt;
    if (length_nxt < SHORTEST_FRAME) begin
      res.kind = KIND_SHORT;
    end else if (command_nxt == CMD_LIGHT) begin
      res.kind           = KIND_LIGHT;
      res.light_integer  = data_word[15:5];
      res.light_fraction = data_word[4:1];
      res.motion         = data_lo_nxt[0];
    end else if (command_nxt == CMD_BUTTON) begin
      res.kind         = KIND_BUTTON;
      res.button_event = data_lo_nxt;
    end else begin
      res.kind = KIND_OTHER;
    end
  end

  assign res_valid = done;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunt_r      <= HUNT_IDLE;
      pos_r       <= 8'd0;
      length_r    <= 8'd0;
      command_r   <= 8'd0;
      data_hi_r   <= 8'd0;
      data_lo_r   <= 8'd0;
      frame_cnt_r <= 16'd0;
    end else begin
      hunt_r      <= hunt_nxt;
      pos_r       <= pos_nxt;
      length_r    <= length_nxt;
      command_r   <= command_nxt;
      data_hi_r   <= data_hi_nxt;
      data_lo_r   <= data_lo_nxt;
      frame_cnt_r <= frame_cnt_nxt;
    end
  end

  // a released frame always returns to hunting
  a_release_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (hunt_r == HUNT_IDLE && pos_r == 8'd0))
    else $error("frame release did not return to hunting");

  // frame counter moves only with a release
  a_cnt_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !res_valid |=> $stable(frame_cnt_r))
    else $error("frame counter changed without a release");

  // position is zero outside a frame
  a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (hunt_r != HUNT_FRAME) |-> (pos_r == 8'd0))
    else $error("byte position set outside a frame");

  // inside a frame the sync pair is behind us
  a_pos_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (hunt_r == HUNT_FRAME) |-> (pos_r >= POS_LENGTH))
    else $error("byte position below length byte inside frame");

endmodule

// ===== sv/sfdd_out_buf.sv =====
module sfdd_out_buf (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  sfdd_pkg::result_t       push_data,
  output logic                    space,
  output logic                    out_valid,
  input  logic                    out_ready,
  output sfdd_pkg::result_t       out_data
);
  import sfdd_pkg::*;

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop       = main_valid_r && out_ready;
  assign space     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  // output word plus one skid word
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!main_valid_r) begin
      main_valid_nxt = push;
      main_nxt       = push_data;
    end else if (pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = push;
        skid_nxt       = push_data;
      end else begin
        main_valid_nxt = push;
        main_nxt       = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  // skid word never sits behind an empty output
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid word held with empty output register");

endmodule

// ===== sv/sensor_frame_deframer_decoder_top.sv =====
// channel   signals                                   direction
// in        in_valid in_ready in_rx_byte              byte in
// out       out_valid out_ready out_kind .. out_frame_seq   decoded frame out
// cfg       cfg_valid cfg_ready cfg_min_frame_bytes   minimum frame length
//
// one byte accepted per cycle while in_ready is high; a released frame is registered in the output buffer before out
// the sync hunt and byte capture are combinational between state regs and the output buffer regs
// a two-word output buffer keeps in_ready high while one result waits
// in_ready drops only with both output words full; cfg_ready is always high
// rst_n is synchronous: hunting restarts, counter zero, minimum back to 11
module sensor_frame_deframer_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_command,
  output logic [10:0] out_light_integer,
  output logic [3:0]  out_light_fraction,
  output logic        out_motion,
  output logic [7:0]  out_button_event,
  output logic [7:0]  out_frame_length,
  output logic [15:0] out_frame_seq,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_min_frame_bytes
);
  import sfdd_pkg::*;

  logic       in_fire;
  logic [7:0] min_bytes_r;
  logic       res_valid;
  result_t    res;
  result_t    out_word;
  logic       space;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = space;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_bytes_r <= MIN_BYTES_RST;
    end else if (cfg_valid) begin
      min_bytes_r <= cfg_min_frame_bytes;
    end
  end

  sfdd_deframer u_deframer (
    .clk             (clk),
    .rst_n           (rst_n),
    .byte_valid      (in_fire),
    .rx_byte         (in_rx_byte),
    .min_frame_bytes (min_bytes_r),
    .res_valid       (res_valid),
    .res             (res)
  );

  sfdd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_word)
  );

  // result word fields
  assign out_kind           = out_word.kind;
  assign out_command        = out_word.command;
  assign out_light_integer  = out_word.light_integer;
  assign out_light_fraction = out_word.light_fraction;
  assign out_motion         = out_word.motion;
  assign out_button_event   = out_word.button_event;
  assign out_frame_length   = out_word.frame_length;
  assign out_frame_seq      = out_word.frame_seq;

endmodule
